// ===== rtl/sss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shearsort mesh sorter package
// Shared widths, reset values, the controller command bundle and helpers.
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_W      = 4;
   localparam int SIDE_DEF   = 8;
   localparam int SIDE_RESET = 8;

   typedef struct packed {
      logic             load;
      logic             shift;
      logic             row_step;
      logic             col_step;
      logic             parity;
      logic [CSR_W-1:0] side;
   } cmd_type;

   function automatic logic [CSR_W-1:0] num_phases(input logic [CSR_W-1:0] side);
      logic [CSR_W-1:0] p;
      p = CSR_W'(1);
      for (int k = 0; k < CSR_W; k++) begin
         if ((CSR_W'(1) << k) < side) begin
            p = p + CSR_W'(1);
         end
      end
      return p;
   endfunction

endpackage

// ===== rtl/sss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shearsort mesh datapath
// Matrix cells with neighbor compare-exchange for row and column steps.
// ----------------------------------------------------------------------------
module sss_datapath #(
   parameter int SIDE = sss_pkg::SIDE_DEF
) (
   input  logic                                clock,
   input  sss_pkg::cmd_type                    cmd,
   input  logic [$clog2(SIDE*SIDE)-1:0]        load_addr,
   input  logic signed [sss_pkg::DATA_W-1:0]   req_value,
   output logic signed [sss_pkg::DATA_W-1:0]   rsp_sorted_value
);
   import sss_pkg::*;

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(SIDE + 1);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] store_in [DEPTH];
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [SW-1:0]            side_idx;

   assign side_idx = cmd.side[SW-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int RT = (i + 1 < DEPTH) ? i + 1 : i;
      localparam int LF = (i > 0) ? i - 1 : i;
      logic [SIDE:0]            inr, codd, cfirst, clast, rodd, rfirst, rlast;
      logic signed [DATA_W-1:0] dn_v [SIDE+1];
      logic signed [DATA_W-1:0] up_v [SIDE+1];

      for (genvar sv = 0; sv <= SIDE; sv++) begin : g_side
         if (sv >= 2) begin : g_on
            localparam int C  = i % sv;
            localparam int R  = i / sv;
            localparam int DN = (i + sv < DEPTH) ? i + sv : i;
            localparam int UP = (i >= sv) ? i - sv : i;
            assign inr[sv]    = (i < sv * sv);
            assign codd[sv]   = ((C % 2) == 1);
            assign cfirst[sv] = (C == 0);
            assign clast[sv]  = (C == sv - 1);
            assign rodd[sv]   = ((R % 2) == 1);
            assign rfirst[sv] = (R == 0);
            assign rlast[sv]  = (R == sv - 1);
            assign dn_v[sv]   = store_ff[DN];
            assign up_v[sv]   = store_ff[UP];
         end else begin : g_off
            assign inr[sv]    = 1'b0;
            assign codd[sv]   = 1'b0;
            assign cfirst[sv] = 1'b0;
            assign clast[sv]  = 1'b0;
            assign rodd[sv]   = 1'b0;
            assign rfirst[sv] = 1'b0;
            assign rlast[sv]  = 1'b0;
            assign dn_v[sv]   = store_ff[i];
            assign up_v[sv]   = store_ff[i];
         end
      end

      always_comb begin
         logic signed [DATA_W-1:0] me, rt, lf, dn, up;
         logic                     asc;
         me  = store_ff[i];
         rt  = store_ff[RT];
         lf  = store_ff[LF];
         dn  = dn_v[side_idx];
         up  = up_v[side_idx];
         asc = !rodd[side_idx];
         store_in[i] = me;
         if (cmd.load && (load_addr == AW'(i))) begin
            store_in[i] = req_value;
         end else if (cmd.shift) begin
            store_in[i] = rt;
         end else if (cmd.row_step && inr[side_idx]) begin
            if (!clast[side_idx] && (codd[side_idx] == cmd.parity)) begin
               store_in[i] = (asc == (rt < me)) ? rt : me;
            end else if (!cfirst[side_idx] && (codd[side_idx] != cmd.parity)) begin
               store_in[i] = (asc == (me < lf)) ? lf : me;
            end
         end else if (cmd.col_step && inr[side_idx]) begin
            if (!rlast[side_idx] && (rodd[side_idx] == cmd.parity)) begin
               store_in[i] = (dn < me) ? dn : me;
            end else if (!rfirst[side_idx] && (rodd[side_idx] != cmd.parity)) begin
               store_in[i] = (me < up) ? up : me;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (cmd.shift) begin
         rsp_value_ff <= store_ff[0];
      end
   end

   assign rsp_sorted_value = rsp_value_ff;

endmodule

// ===== rtl/sss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shearsort mesh controller
// Sequences load, row and column sort steps, phases and the result drain.
// ----------------------------------------------------------------------------
module sss_ctrl #(
   parameter int SIDE = sss_pkg::SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sss_pkg::CSR_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_last,
   output sss_pkg::cmd_type                cmd,
   output logic [$clog2(SIDE*SIDE)-1:0]    load_addr
);
   import sss_pkg::*;

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SORT, S_EMIT} state_type;

   state_type        state_ff, state_in;
   logic [CSR_W-1:0] csr_side_ff, csr_side_in;
   logic [NW-1:0]    load_cnt_ff, load_cnt_in;
   logic [CSR_W-1:0] phase_ff, phase_in;
   logic [CSR_W-1:0] step_ff, step_in;
   logic             col_ff, col_in;
   logic [NW-1:0]    emit_cnt_ff, emit_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [CSR_W-1:0] side;
   logic [NW-1:0]    n_items;
   logic [NW:0]      cnt_next;
   logic             accept, fire;

   always_comb begin
      if (csr_side_ff < CSR_W'(2)) begin
         side = CSR_W'(2);
      end else if (csr_side_ff > CSR_W'(SIDE)) begin
         side = CSR_W'(SIDE);
      end else begin
         side = csr_side_ff;
      end
   end

   assign n_items   = NW'(side) * NW'(side);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign cnt_next  = {1'b0, load_cnt_ff} + (NW+1)'(1);
   assign load_addr = load_cnt_ff[AW-1:0];

   always_comb begin
      cmd.load     = accept;
      cmd.shift    = fire;
      cmd.row_step = (state_ff == S_SORT) && !col_ff;
      cmd.col_step = (state_ff == S_SORT) && col_ff;
      cmd.parity   = step_ff[0];
      cmd.side     = side;
   end

   always_comb begin
      state_in     = state_ff;
      csr_side_in  = csr_wr_en ? csr_wr_data : csr_side_ff;
      load_cnt_in  = load_cnt_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      col_in       = col_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cnt_next >= {1'b0, n_items}) begin
                  load_cnt_in = '0;
                  phase_in    = '0;
                  step_in     = '0;
                  col_in      = 1'b0;
                  state_in    = S_SORT;
               end else begin
                  load_cnt_in = cnt_next[NW-1:0];
               end
            end
         end
         S_SORT: begin
            if (step_ff == side - CSR_W'(1)) begin
               step_in = '0;
               if (col_ff) begin
                  col_in   = 1'b0;
                  phase_in = phase_ff + CSR_W'(1);
               end else if (phase_ff == num_phases(side) - CSR_W'(1)) begin
                  emit_cnt_in = '0;
                  state_in    = S_EMIT;
               end else begin
                  col_in = 1'b1;
               end
            end else begin
               step_in = step_ff + CSR_W'(1);
            end
         end
         S_EMIT: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (emit_cnt_ff == n_items - NW'(1));
               emit_cnt_in  = emit_cnt_ff + NW'(1);
               if (emit_cnt_ff == n_items - NW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_side_ff  <= CSR_W'(SIDE_RESET);
         load_cnt_ff  <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         col_ff       <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_side_ff  <= csr_side_in;
         load_cnt_ff  <= load_cnt_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         col_ff       <= col_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_last = rsp_last_ff;

endmodule

// ===== rtl/shearsort_mesh_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shearsort mesh sorter core
// Loads a square matrix row-major, shearsorts it into snake order and returns it row-major.
// ----------------------------------------------------------------------------
// Requests carry one signed matrix element each on req_value and are taken
// whenever the core is idle, one per cycle. The side length comes from the
// csr_wr_data register, clamped to the range two to SIDE; the user must see
// that it is written only while the core is idle, as the core does not enforce
// it. The request that completes the side-squared matrix starts the sort of
// phases = ceil(log2(side)) + 1 phases, each a row sort and a column sort but
// the last, which is a row sort only, all made of the odd-even transposition
// steps of the cell mesh. The matrix then drains row-major through the rsp
// channel, one element per cycle while rsp_ready is high, with rsp_is_last on
// the final element. A stalled receiver freezes the drain; no request is taken
// until the final element has been presented.
// A synchronous reset returns the core to idle with the load count cleared and
// the side register at eight; matrix contents are not cleared.
// ----------------------------------------------------------------------------
module shearsort_mesh_sorter_core #(
   parameter int SIDE = sss_pkg::SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sss_pkg::CSR_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sss_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sss_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_is_last
);
   import sss_pkg::*;

   cmd_type                      cmd;
   logic [$clog2(SIDE*SIDE)-1:0] load_addr;

   sss_ctrl #(.SIDE(SIDE)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_is_last (rsp_is_last),
      .cmd         (cmd),
      .load_addr   (load_addr)
   );

   sss_datapath #(.SIDE(SIDE)) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .load_addr        (load_addr),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value)
   );

`ifndef ASSERT_OFF
   // After the final element is taken, nothing is shown until a new matrix sorts.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_is_last) |=> !rsp_valid)
      else $error("result shown right after the final element");

   // While a matrix drains, requests are held off.
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_last) |-> !req_ready)
      else $error("request taken during drain");

   // Loading and draining never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.load) |-> !cmd.shift && !cmd.row_step && !cmd.col_step)
      else $error("load overlaps sort or drain");
`endif

endmodule
